[rtl/core/psms_pkg.sv]
// shared types and constants of the power source monitor and selector
package psms_pkg;

	localparam int unsigned NumSlots = 3;
	localparam int unsigned VoltW    = 12;

	typedef logic [VoltW-1:0] volt_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_LITHIUM = 2'd1,
		KIND_ADAPTER = 2'd2,
		KIND_DRY     = 2'd3
	} kind_t;

	typedef enum logic {
		OP_FULL  = 1'b0,
		OP_QUICK = 1'b1
	} op_t;

	localparam logic [1:0] SLOT_A = 2'd0;
	localparam logic [1:0] SLOT_B = 2'd1;
	localparam logic [1:0] SLOT_C = 2'd2;

	localparam logic [1:0] REG_MIN_VOLTAGE  = 2'd0;
	localparam logic [1:0] REG_MAX_VOLTAGE  = 2'd1;
	localparam logic [1:0] REG_PRESENCE_THR = 2'd2;

	localparam logic [5:0] LINES_A = 6'd31;
	localparam logic [5:0] LINES_B = 6'd16;
	localparam logic [5:0] LINES_C = 6'd44;

	typedef struct packed {
		volt_t min_voltage;
		volt_t max_voltage;
		volt_t presence_threshold;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] slot;
		volt_t      sample;
		logic       lithium_present;
	} item_t;

	typedef struct packed {
		logic  [NumSlots-1:0] avail;
		kind_t [NumSlots-1:0] kind;
		volt_t [NumSlots-1:0] volt;
	} slots_t;

	typedef struct packed {
		logic [1:0] selected_slot;
		logic [5:0] switch_lines;
		logic       slot_available;
		kind_t      slot_kind;
	} result_t;

	function automatic logic [5:0] lines_of(input logic [1:0] sel);
		logic [5:0] l;
		case (sel)
			SLOT_A:  l = LINES_A;
			SLOT_B:  l = LINES_B;
			default: l = LINES_C;
		endcase
		return l;
	endfunction

endpackage

[rtl/core/power_source_monitor_selector_top.sv]
// top level of the power source monitor and selector
//
// usage
// - input channel (in_valid/in_ready): one transaction is a voltage sample for
//   one slot with its op (full or quick check) and the smart battery flag
// - output channel (out_valid/out_ready): one transaction per input, giving the
//   selected slot, its switch-line pattern and the updated slot's status
// - config port: cfg_we with cfg_index and cfg_data writes one of min, max
//   and presence threshold; write only while the block is idle
// - path: an accepted input goes into the input register, then through the
//   update logic into the result register, which raises out_valid
// - throughput: one transaction per cycle unless out_ready stalls it; the slot
//   state update and the selection are one short compare-and-select pass
//   over three slot registers
// - stall: when the receiver holds out_ready low the result register and the
//   input register both hold, and in_ready drops once both are full
// - reset: all slots unavailable, kind unknown, voltage zero, window 0..4095,
//   presence threshold 100, both pipeline registers empty
module power_source_monitor_selector_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [11:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [1:0]           slot,
	input  logic [11:0]          sample,
	input  logic                 lithium_present,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           selected_slot,
	output logic [5:0]           switch_lines,
	output logic                 slot_available,
	output logic [1:0]           slot_kind
);
	import psms_pkg::*;

	cfg_t    cfg_q;
	slots_t  slots_q;
	slots_t  slots_nxt;
	item_t   item_s1;
	logic    v_s1;
	result_t res_s2;
	result_t res_nxt;
	logic    v_s2;
	logic    adv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_voltage        <= '0;
			cfg_q.max_voltage        <= '1;
			cfg_q.presence_threshold <= VoltW'(100);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_VOLTAGE:  cfg_q.min_voltage        <= cfg_data;
				REG_MAX_VOLTAGE:  cfg_q.max_voltage        <= cfg_data;
				REG_PRESENCE_THR: cfg_q.presence_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1   = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.op              <= op_t'(op);
			item_s1.slot            <= slot;
			item_s1.sample          <= sample;
			item_s1.lithium_present <= lithium_present;
		end
	end

	psms_update u_update (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (slots_q),
		.nxt  (slots_nxt),
		.res  (res_nxt)
	);

	// slot state commits as the transaction enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q.avail <= '0;
			for (int i = 0; i < NumSlots; i++) begin
				slots_q.kind[i] <= KIND_UNKNOWN;
			end
			slots_q.volt <= '0;
		end else if (adv_s1) begin
			slots_q <= slots_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = v_s2;
	assign selected_slot  = res_s2.selected_slot;
	assign switch_lines   = res_s2.switch_lines;
	assign slot_available = res_s2.slot_available;
	assign slot_kind      = res_s2.slot_kind;

	// switch pattern always matches the chosen slot
	a_lines_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (switch_lines == lines_of(selected_slot)))
		else $error("switch lines do not match selected slot");

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (selected_slot != 2'd3))
		else $error("selected slot out of range");

	a_s1_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted transaction lost in stage 1");

	a_s2_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("stage 1 advanced without filling the result register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_ready) |-> !adv_s1)
		else $error("result register overwritten while stalled");

endmodule

[rtl/core/psms_update.sv]
// next slot state and source selection for one sample
module psms_update (
	input  psms_pkg::cfg_t    cfg,
	input  psms_pkg::item_t   item,
	input  psms_pkg::slots_t  cur,
	output psms_pkg::slots_t  nxt,
	output psms_pkg::result_t res
);
	import psms_pkg::*;

	logic    in_window;
	logic    out_window;
	kind_t   ab_kind;
	kind_t   c_kind;
	logic [1:0] sel;
	logic    a_higher;

	assign in_window  = (item.sample > cfg.min_voltage) && (item.sample < cfg.max_voltage);
	assign out_window = (item.sample < cfg.min_voltage) || (item.sample > cfg.max_voltage);

	always_comb begin
		if (item.lithium_present) begin
			ab_kind = KIND_LITHIUM;
		end else if (item.sample > cfg.presence_threshold) begin
			ab_kind = KIND_ADAPTER;
		end else begin
			ab_kind = KIND_UNKNOWN;
		end
		c_kind = (item.sample < cfg.presence_threshold) ? KIND_UNKNOWN : KIND_DRY;
	end

	// only the addressed slot changes; slot index three touches nothing
	always_comb begin
		nxt = cur;
		for (int i = 0; i < NumSlots; i++) begin
			if (item.slot == i[1:0]) begin
				if (item.op == OP_FULL) begin
					if (in_window) begin
						if (cur.kind[i] == KIND_UNKNOWN) begin
							nxt.avail[i] = 1'b1;
						end
					end else begin
						nxt.avail[i] = 1'b0;
					end
					nxt.kind[i] = (i == NumSlots - 1) ? c_kind : ab_kind;
					nxt.volt[i] = item.sample;
				end else if (out_window) begin
					nxt.avail[i] = 1'b0;
				end
			end
		end
	end

	// priority rule on the updated state
	assign a_higher = nxt.volt[0] > nxt.volt[1];

	always_comb begin
		if (nxt.avail[0] && nxt.avail[1]) begin
			if (nxt.kind[0] == KIND_ADAPTER) begin
				if (nxt.kind[1] == KIND_LITHIUM) begin
					sel = SLOT_A;
				end else begin
					sel = a_higher ? SLOT_B : SLOT_A;
				end
			end else if (nxt.kind[1] == KIND_ADAPTER) begin
				sel = SLOT_B;
			end else begin
				sel = a_higher ? SLOT_B : SLOT_A;
			end
		end else if (nxt.avail[0]) begin
			sel = SLOT_A;
		end else if (nxt.avail[1]) begin
			sel = SLOT_B;
		end else begin
			sel = SLOT_C;
		end
	end

	always_comb begin
		res.selected_slot = sel;
		res.switch_lines  = lines_of(sel);
		case (item.slot)
			SLOT_A, SLOT_B, SLOT_C: begin
				res.slot_available = nxt.avail[item.slot];
				res.slot_kind      = nxt.kind[item.slot];
			end
			default: begin
				res.slot_available = 1'b0;
				res.slot_kind      = KIND_UNKNOWN;
			end
		endcase
	end

endmodule
